@@ src/hrfp_pkg.sv @@
// Shared types, codes and helper functions of the reply frame parser.
package hrfp_pkg;

    // Result kinds carried on the master tuser.
    localparam logic [1:0] KIND_STORE   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Table selectors.
    localparam logic [2:0] TAB_ANGLE   = 3'd0;
    localparam logic [2:0] TAB_FORCE   = 3'd1;
    localparam logic [2:0] TAB_CURRENT = 3'd2;
    localparam logic [2:0] TAB_ERROR   = 3'd3;
    localparam logic [2:0] TAB_STATUS  = 3'd4;
    localparam logic [2:0] TAB_NONE    = 3'd5;

    // Register codes found in bytes 5 and 6 of a reply.
    localparam logic [15:0] REG_ANGLE    = 16'd1546;
    localparam logic [15:0] REG_FORCE    = 16'd1582;
    localparam logic [15:0] REG_CURRENT  = 16'd1594;
    localparam logic [15:0] REG_ERROR    = 16'd1606;
    localparam logic [15:0] REG_STATUS   = 16'd1612;
    localparam logic [15:0] REG_ACK_1004 = 16'd1004;
    localparam logic [15:0] REG_ACK_1006 = 16'd1006;
    localparam logic [15:0] REG_ACK_1009 = 16'd1009;
    localparam logic [15:0] REG_ACK_1020 = 16'd1020;
    localparam logic [15:0] REG_ACK_1522 = 16'd1522;
    localparam logic [15:0] REG_ACK_1498 = 16'd1498;

    // Frame classes.
    localparam logic [3:0] CLS_IGNORED  = 4'd0;
    localparam logic [3:0] CLS_ACK_1004 = 4'd6;
    localparam logic [3:0] CLS_ACK_1006 = 4'd7;
    localparam logic [3:0] CLS_ACK_1009 = 4'd8;
    localparam logic [3:0] CLS_ACK_1020 = 4'd9;
    localparam logic [3:0] CLS_ACK_1522 = 4'd10;
    localparam logic [3:0] CLS_ACK_1498 = 4'd11;
    localparam logic [3:0] CLS_OTHER    = 4'd12;

    // First data byte of a reply.
    localparam int unsigned FIRST_DATA = 7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  tab;
        logic [2:0]  joint;
        logic [15:0] value;
        logic [3:0]  cls;
        logic        last;
    } t_result;

    // Fold a 16-bit word: values above 0x8000 become 65536 minus the value.
    function automatic logic [15:0] fold16(input logic [15:0] v);
        logic [15:0] neg;
        neg = (~v) + 16'd1;
        return v[15] ? neg : v;
    endfunction

    function automatic logic [2:0] table_of(input logic [15:0] code);
        logic [2:0] t;
        case (code)
            REG_ANGLE:   t = TAB_ANGLE;
            REG_FORCE:   t = TAB_FORCE;
            REG_CURRENT: t = TAB_CURRENT;
            REG_ERROR:   t = TAB_ERROR;
            REG_STATUS:  t = TAB_STATUS;
            default:     t = TAB_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] class_of(input logic [15:0] code);
        logic [3:0] c;
        case (code)
            REG_ANGLE, REG_FORCE, REG_CURRENT, REG_ERROR, REG_STATUS:
                c = {1'b0, table_of(code)} + 4'd1;
            REG_ACK_1004: c = CLS_ACK_1004;
            REG_ACK_1006: c = CLS_ACK_1006;
            REG_ACK_1009: c = CLS_ACK_1009;
            REG_ACK_1020: c = CLS_ACK_1020;
            REG_ACK_1522: c = CLS_ACK_1522;
            REG_ACK_1498: c = CLS_ACK_1498;
            default:      c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

@@ src/hand_reply_frame_parser.sv @@
// Reply frame parser: byte stream in, stored values, frame summaries and read data out.
// Each result is written into the result queue when its beat is accepted.
// One beat per cycle while the queue has room; a beat that yields a stored value and
// a summary puts two master beats into a four-entry result queue.
// Input ready drops while the queue has fewer than two free entries.
// Reset (synchronous, active low) clears frame state, the queue, all tables and
// sets device_id to 1.
module hand_reply_frame_parser #(
    parameter int MAX_FRAME = 1024,
    parameter int JOINTS    = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // device_id
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // rx_byte[7:0], table_sel[10:8], joint_sel[13:11]
    input  logic        i_s_axis_tlast,   // frame_end
    input  logic [0:0]  i_s_axis_tuser,   // mode
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // table_res[2:0], joint[5:3], value[21:6],
                                          // frame_class[25:22]
    output logic        o_m_axis_tlast,   // is_last
    output logic [1:0]  o_m_axis_tuser    // kind
);

    localparam int PW  = $clog2(MAX_FRAME + 1);
    localparam int VW  = $clog2(JOINTS + 1);
    localparam int JIW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // Configuration.
    logic [7:0] r_device_id;

    // Frame state.
    logic [PW-1:0] r_pos,        n_pos;
    logic          r_id_ok,      n_id_ok;
    logic [15:0]   r_code,       n_code;
    logic [VW-1:0] r_taken,      n_taken;
    logic [7:0]    r_low_byte,   n_low_byte;
    logic [15:0]   r_pend_value, n_pend_value;
    logic          r_pend_valid, n_pend_valid;

    // Tables.
    logic [15:0] r_angle   [JOINTS];
    logic [15:0] r_force   [JOINTS];
    logic [15:0] r_current [JOINTS];
    logic [7:0]  r_error   [JOINTS];
    logic [7:0]  r_status  [JOINTS];

    // Result queue.
    hrfp_pkg::t_result r_q [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;

    logic        s_accept;
    logic        m_pop;
    logic        in_mode;
    logic [7:0]  in_byte;
    logic [2:0]  in_tab;
    logic [2:0]  in_joint;
    logic [2:0]  cur_tab;
    logic        pos_live;
    logic        store_go;
    logic [15:0] rd_value;
    logic        res0_v, res1_v;
    hrfp_pkg::t_result res0, res1, store_res, sum_res;
    hrfp_pkg::t_result q_head;

    assign s_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign m_pop    = o_m_axis_tvalid & i_m_axis_tready;
    assign in_mode  = i_s_axis_tuser[0];
    assign in_byte  = i_s_axis_tdata[7:0];
    assign in_tab   = i_s_axis_tdata[10:8];
    assign in_joint = i_s_axis_tdata[13:11];

    // Accept only with room for the two results a beat can cause.
    assign o_s_axis_tready = (r_cnt <= 3'd2);

    assign q_head          = r_q[r_rp];
    assign o_m_axis_tvalid = (r_cnt != 3'd0);
    assign o_m_axis_tuser  = q_head.kind;
    assign o_m_axis_tlast  = q_head.last;
    assign o_m_axis_tdata  = {6'd0, q_head.cls, q_head.value, q_head.joint, q_head.tab};

    assign cur_tab  = hrfp_pkg::table_of(r_code);
    assign pos_live = (r_pos < PW'(MAX_FRAME));
    // Commit the pending value when a later byte of the same frame shows up.
    assign store_go = pos_live && r_pend_valid && r_id_ok && (cur_tab != hrfp_pkg::TAB_NONE)
                      && (r_taken < VW'(JOINTS));

    // Read mux; out-of-range table or joint reads zero.
    always_comb begin
        rd_value = 16'd0;
        if ({1'b0, in_joint} < 4'(JOINTS)) begin
            case (in_tab)
                hrfp_pkg::TAB_ANGLE:   rd_value = r_angle[in_joint[JIW-1:0]];
                hrfp_pkg::TAB_FORCE:   rd_value = r_force[in_joint[JIW-1:0]];
                hrfp_pkg::TAB_CURRENT: rd_value = r_current[in_joint[JIW-1:0]];
                hrfp_pkg::TAB_ERROR:   rd_value = {8'd0, r_error[in_joint[JIW-1:0]]};
                hrfp_pkg::TAB_STATUS:  rd_value = {8'd0, r_status[in_joint[JIW-1:0]]};
                default:               rd_value = 16'd0;
            endcase
        end
    end

    // Per-beat frame parsing.
    always_comb begin
        n_pos        = r_pos;
        n_id_ok      = r_id_ok;
        n_code       = r_code;
        n_taken      = r_taken;
        n_low_byte   = r_low_byte;
        n_pend_value = r_pend_value;
        n_pend_valid = r_pend_valid;
        res0_v       = 1'b0;
        res1_v       = 1'b0;

        store_res.kind  = hrfp_pkg::KIND_STORE;
        store_res.tab   = cur_tab;
        store_res.joint = 3'(r_taken);
        store_res.value = r_pend_value;
        store_res.cls   = {1'b0, cur_tab} + 4'd1;
        store_res.last  = ~i_s_axis_tlast;

        sum_res.kind  = hrfp_pkg::KIND_SUMMARY;
        sum_res.tab   = 3'd0;
        sum_res.joint = 3'd0;
        sum_res.value = 16'd0;
        sum_res.cls   = hrfp_pkg::CLS_IGNORED;
        sum_res.last  = 1'b1;

        res0 = store_res;
        res1 = sum_res;

        if (in_mode) begin
            res0.kind  = hrfp_pkg::KIND_READ;
            res0.tab   = in_tab;
            res0.joint = in_joint;
            res0.value = rd_value;
            res0.cls   = hrfp_pkg::CLS_IGNORED;
            res0.last  = 1'b1;
            res0_v     = 1'b1;
        end else begin
            if (pos_live) begin
                if (store_go) begin
                    n_taken = r_taken + VW'(1);
                end
                n_pend_valid = 1'b0;
                if (r_pos == PW'(2)) begin
                    n_id_ok = (in_byte == r_device_id);
                end else if (r_pos == PW'(5)) begin
                    n_code = {8'd0, in_byte};
                end else if (r_pos == PW'(6)) begin
                    n_code = hrfp_pkg::fold16({in_byte, r_code[7:0]});
                end else if (r_pos >= PW'(hrfp_pkg::FIRST_DATA) && r_id_ok
                             && cur_tab != hrfp_pkg::TAB_NONE) begin
                    if (cur_tab <= hrfp_pkg::TAB_CURRENT) begin
                        // Odd positions hold the low byte of a pair.
                        if (r_pos[0]) begin
                            n_low_byte = in_byte;
                        end else begin
                            n_pend_value = hrfp_pkg::fold16({in_byte, r_low_byte});
                            n_pend_valid = 1'b1;
                        end
                    end else begin
                        n_pend_value = {8'd0, in_byte};
                        n_pend_valid = 1'b1;
                    end
                end
                n_pos = r_pos + PW'(1);
            end

            if (i_s_axis_tlast) begin
                if (n_id_ok && n_pos >= PW'(hrfp_pkg::FIRST_DATA)) begin
                    sum_res.cls = hrfp_pkg::class_of(n_code);
                end
                // Drop all per-frame state at the end mark.
                n_pos        = '0;
                n_id_ok      = 1'b0;
                n_code       = 16'd0;
                n_taken      = '0;
                n_low_byte   = 8'd0;
                n_pend_value = 16'd0;
                n_pend_valid = 1'b0;
            end

            if (store_go) begin
                res0   = store_res;
                res0_v = 1'b1;
                res1   = sum_res;
                res1_v = i_s_axis_tlast;
            end else begin
                res0   = sum_res;
                res0_v = i_s_axis_tlast;
            end
        end
    end

    // Queue pointers.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (s_accept) begin
            n_wp  = r_wp + {1'b0, res0_v} + {1'b0, res1_v};
            n_cnt = n_cnt + {2'd0, res0_v} + {2'd0, res1_v};
        end
        if (m_pop) begin
            n_rp  = r_rp + 2'd1;
            n_cnt = n_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id  <= 8'd1;
            r_pos        <= '0;
            r_id_ok      <= 1'b0;
            r_code       <= 16'd0;
            r_taken      <= '0;
            r_low_byte   <= 8'd0;
            r_pend_value <= 16'd0;
            r_pend_valid <= 1'b0;
            r_wp         <= 2'd0;
            r_rp         <= 2'd0;
            r_cnt        <= 3'd0;
            for (int k = 0; k < JOINTS; k++) begin
                r_angle[k]   <= 16'd0;
                r_force[k]   <= 16'd0;
                r_current[k] <= 16'd0;
                r_error[k]   <= 8'd0;
                r_status[k]  <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_device_id <= i_cfg_wdata;
            end
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            if (s_accept && !in_mode) begin
                r_pos        <= n_pos;
                r_id_ok      <= n_id_ok;
                r_code       <= n_code;
                r_taken      <= n_taken;
                r_low_byte   <= n_low_byte;
                r_pend_value <= n_pend_value;
                r_pend_valid <= n_pend_valid;
                if (store_go) begin
                    case (cur_tab)
                        hrfp_pkg::TAB_ANGLE:   r_angle[r_taken[JIW-1:0]]   <= r_pend_value;
                        hrfp_pkg::TAB_FORCE:   r_force[r_taken[JIW-1:0]]   <= r_pend_value;
                        hrfp_pkg::TAB_CURRENT: r_current[r_taken[JIW-1:0]] <= r_pend_value;
                        hrfp_pkg::TAB_ERROR:   r_error[r_taken[JIW-1:0]]   <= r_pend_value[7:0];
                        hrfp_pkg::TAB_STATUS:  r_status[r_taken[JIW-1:0]]  <= r_pend_value[7:0];
                        default: ;
                    endcase
                end
            end
        end
    end

    // Result queue payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_accept && res0_v) begin
            r_q[r_wp] <= res0;
        end
        if (s_accept && res1_v) begin
            r_q[r_wp + 2'd1] <= res1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_mode) |=> o_m_axis_tvalid)
        else $error("read beat left no result");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !in_mode && i_s_axis_tlast) |=> (r_pos == '0 && !r_pend_valid))
        else $error("frame state not cleared at end mark");

    a_taken_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= VW'(JOINTS))
        else $error("too many values taken");

    a_pend_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pos >= PW'(hrfp_pkg::FIRST_DATA + 1)))
        else $error("pending value before data bytes");
`endif

endmodule

@@ test/tb_hand_reply_frame_parser.sv @@
// Self-checking testbench for hand_reply_frame_parser: byte-stream frames and reads in, results checked against a mirror.
module tb_hand_reply_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME_LEN = 1024;
    localparam int JOINT_CNT     = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 85;

    // Every register code the parser knows; table codes come first.
    localparam logic [15:0] KNOWN_CODES [11] = '{
        hrfp_pkg::REG_ANGLE, hrfp_pkg::REG_FORCE, hrfp_pkg::REG_CURRENT,
        hrfp_pkg::REG_ERROR, hrfp_pkg::REG_STATUS,
        hrfp_pkg::REG_ACK_1004, hrfp_pkg::REG_ACK_1006, hrfp_pkg::REG_ACK_1009,
        hrfp_pkg::REG_ACK_1020, hrfp_pkg::REG_ACK_1522, hrfp_pkg::REG_ACK_1498
    };

    // Mirror of the parser: frame state, the five joint tables and the results still owed.
    class hand_state_mirror;
        logic [7:0]        dev_id;
        logic [10:0]       pos;
        bit                id_ok;
        logic [15:0]       reg_code;
        int unsigned       taken;
        logic [7:0]        low_byte;
        logic [15:0]       held_word;
        bit                held;
        logic [15:0]       tab_mem [5][JOINT_CNT];
        hrfp_pkg::t_result owed_results[$];
        int unsigned       mismatches;

        function new();
            dev_id     = 8'd1;
            mismatches = 0;
            clear_frame();
            foreach (tab_mem[t, j]) tab_mem[t][j] = '0;
        endfunction

        function void clear_frame();
            pos       = '0;
            id_ok     = 1'b0;
            reg_code  = '0;
            taken     = 0;
            low_byte  = '0;
            held_word = '0;
            held      = 1'b0;
        endfunction

        // Negative words come back as magnitudes; 0x8000 has no positive twin and stays.
        function logic [15:0] fold_word(logic [15:0] w);
            int mag;
            mag = 65536 - int'(w);
            return (w > 16'h8000) ? mag[15:0] : w;
        endfunction

        function logic [2:0] tab_for_code(logic [15:0] c);
            case (c)
                hrfp_pkg::REG_ANGLE:   return hrfp_pkg::TAB_ANGLE;
                hrfp_pkg::REG_FORCE:   return hrfp_pkg::TAB_FORCE;
                hrfp_pkg::REG_CURRENT: return hrfp_pkg::TAB_CURRENT;
                hrfp_pkg::REG_ERROR:   return hrfp_pkg::TAB_ERROR;
                hrfp_pkg::REG_STATUS:  return hrfp_pkg::TAB_STATUS;
                default:               return hrfp_pkg::TAB_NONE;
            endcase
        endfunction

        function logic [3:0] class_for_code(logic [15:0] c);
            logic [2:0] t;
            t = tab_for_code(c);
            if (t != hrfp_pkg::TAB_NONE) return {1'b0, t} + 4'd1;
            case (c)
                hrfp_pkg::REG_ACK_1004: return hrfp_pkg::CLS_ACK_1004;
                hrfp_pkg::REG_ACK_1006: return hrfp_pkg::CLS_ACK_1006;
                hrfp_pkg::REG_ACK_1009: return hrfp_pkg::CLS_ACK_1009;
                hrfp_pkg::REG_ACK_1020: return hrfp_pkg::CLS_ACK_1020;
                hrfp_pkg::REG_ACK_1522: return hrfp_pkg::CLS_ACK_1522;
                hrfp_pkg::REG_ACK_1498: return hrfp_pkg::CLS_ACK_1498;
                default:                return hrfp_pkg::CLS_OTHER;
            endcase
        endfunction

        function logic [15:0] entry(logic [2:0] tsel, logic [2:0] jsel);
            if (jsel >= JOINT_CNT || tsel > hrfp_pkg::TAB_STATUS) return '0;
            return tab_mem[tsel][jsel];
        endfunction

        // Work out what one accepted input beat yields and queue it.
        function void take_beat(bit mode, logic [7:0] b, bit fend,
                                logic [2:0] tsel, logic [2:0] jsel);
            hrfp_pkg::t_result fresh[$];
            hrfp_pkg::t_result r;
            logic [2:0]        t;
            if (mode) begin
                r = '{hrfp_pkg::KIND_READ, tsel, jsel, entry(tsel, jsel),
                      hrfp_pkg::CLS_IGNORED, 1'b1};
                owed_results.push_back(r);
                return;
            end
            if (pos < MAX_FRAME_LEN) begin
                t = tab_for_code(reg_code);
                // A held value lands only now that a later byte of its frame showed up.
                if (held) begin
                    if (id_ok && t != hrfp_pkg::TAB_NONE && taken < JOINT_CNT) begin
                        tab_mem[t][taken] = (t >= hrfp_pkg::TAB_ERROR)
                                            ? {8'h00, held_word[7:0]} : held_word;
                        r = '{hrfp_pkg::KIND_STORE, t, 3'(taken), held_word,
                              {1'b0, t} + 4'd1, 1'b0};
                        fresh.push_back(r);
                        taken++;
                    end
                    held = 1'b0;
                end
                if (pos == 2) begin
                    id_ok = (b == dev_id);
                end else if (pos == 5) begin
                    reg_code = {8'h00, b};
                end else if (pos == 6) begin
                    reg_code = fold_word({b, reg_code[7:0]});
                end else if (pos >= hrfp_pkg::FIRST_DATA && id_ok
                             && t != hrfp_pkg::TAB_NONE) begin
                    if (t <= hrfp_pkg::TAB_CURRENT) begin
                        if (((pos - hrfp_pkg::FIRST_DATA) % 2) == 0) begin
                            low_byte = b;
                        end else begin
                            held_word = fold_word({b, low_byte});
                            held      = 1'b1;
                        end
                    end else begin
                        held_word = {8'h00, b};
                        held      = 1'b1;
                    end
                end
                pos = pos + 11'd1;
            end
            if (fend) begin
                r = '{hrfp_pkg::KIND_SUMMARY, 3'd0, 3'd0, 16'd0,
                      (id_ok && pos >= hrfp_pkg::FIRST_DATA) ? class_for_code(reg_code)
                                                             : hrfp_pkg::CLS_IGNORED,
                      1'b0};
                fresh.push_back(r);
                clear_frame();
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i]) owed_results.push_back(fresh[i]);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task cmp_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        endtask

        task match_result(hrfp_pkg::t_result got);
            hrfp_pkg::t_result want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value %0h",
                                          got.kind, got.value));
                return;
            end
            want = owed_results.pop_front();
            cmp_field("kind",        16'(got.kind),  16'(want.kind));
            cmp_field("table",       16'(got.tab),   16'(want.tab));
            cmp_field("joint",       16'(got.joint), 16'(want.joint));
            cmp_field("value",       got.value,      want.value);
            cmp_field("frame_class", 16'(got.cls),   16'(want.cls));
            cmp_field("is_last",     16'(got.last),  16'(want.last));
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [7:0]  i_cfg_wdata     = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;  // rx_byte[7:0], table_sel[10:8], joint_sel[13:11]
    logic        i_s_axis_tlast  = 1'b0; // frame_end
    logic [0:0]  i_s_axis_tuser  = '0;  // mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // table_res[2:0], joint[5:3], value[21:6],
                                        // frame_class[25:22]
    logic        o_m_axis_tlast;        // is_last
    logic [1:0]  o_m_axis_tuser;        // kind

    hand_state_mirror  tracker = new();
    hrfp_pkg::t_result seen;
    int                gap_pct    = 0;  // chance per cycle that the sender holds off
    int                stall_pct  = 0;  // chance per cycle that the receiver stalls
    int                read_pct   = 0;  // chance of a table read slipped in before a frame byte
    int                beats_sent = 0;

    hand_reply_frame_parser #(
        .MAX_FRAME (MAX_FRAME_LEN),
        .JOINTS    (JOINT_CNT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at random, one decision per cycle.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both sides at each edge: record register writes and input beats first,
    // then check any result beat against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.dev_id = i_cfg_wdata;
            if (i_s_axis_tvalid && o_s_axis_tready)
                tracker.take_beat(i_s_axis_tuser[0], i_s_axis_tdata[7:0], i_s_axis_tlast,
                                  i_s_axis_tdata[10:8], i_s_axis_tdata[13:11]);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.kind  = o_m_axis_tuser;
                seen.tab   = o_m_axis_tdata[2:0];
                seen.joint = o_m_axis_tdata[5:3];
                seen.value = o_m_axis_tdata[21:6];
                seen.cls   = o_m_axis_tdata[25:22];
                seen.last  = o_m_axis_tlast;
                tracker.match_result(seen);
            end
        end
    end

    // Hold off at random, then present one beat and hold it until taken.
    task automatic send_beat(input logic user, input logic [15:0] data, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        i_s_axis_tuser  <= user;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Read beat: the byte and end mark are don't-care, so fill them with noise.
    task automatic read_beat(input logic [2:0] tsel, input logic [2:0] jsel);
        send_beat(1'b1, {2'b00, jsel, tsel, 8'($urandom)}, 1'($urandom));
    endtask

    // Frame byte: the selector bits are don't-care, so fill them with noise.
    task automatic byte_beat(input logic [7:0] b, input logic last);
        send_beat(1'b0, {2'b00, 3'($urandom), 3'($urandom), b}, last);
    endtask

    task automatic send_frame(input logic [7:0] frame_bytes[$]);
        foreach (frame_bytes[i]) begin
            if ($urandom_range(99) < read_pct) read_beat(3'($urandom), 3'($urandom));
            byte_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Wrap payload bytes in a reply header: two filler bytes, id, two filler bytes, code.
    task automatic send_reply(input logic [7:0] id, input logic [15:0] code,
                              input logic [7:0] payload[$]);
        logic [7:0] f[$];
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        f.push_back(id);
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        f.push_back(code[7:0]);
        f.push_back(code[15:8]);
        foreach (payload[i]) f.push_back(payload[i]);
        send_frame(f);
    endtask

    // Mostly well-formed replies with random content; the rest reads and short junk.
    task automatic random_item();
        int          roll;
        int          n;
        logic [7:0]  id;
        logic [15:0] code;
        logic [7:0]  d[$];
        roll = $urandom_range(99);
        if (roll < 70) begin
            id   = ($urandom_range(9) < 8) ? tracker.dev_id : 8'($urandom);
            code = ($urandom_range(2) != 0) ? KNOWN_CODES[$urandom_range(4)]
                                            : KNOWN_CODES[$urandom_range(10)];
            case ($urandom_range(9))
                0:       code = 16'(17'h10000 - code);  // negated code folds back
                1:       code = 16'($urandom);
                default: ;
            endcase
            n = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(16);
            repeat (n) d.push_back(8'($urandom));
            send_reply(id, code, d);
        end else if (roll < 82) begin
            read_beat(3'($urandom), 3'($urandom));
        end else begin
            n = $urandom_range(1, 9);
            repeat (n) d.push_back(8'($urandom));
            if (n > 2 && $urandom_range(1) == 1) d[2] = tracker.dev_id;
            send_frame(d);
        end
    endtask

    task automatic random_run(input int n);
        beats_sent = 0;
        read_pct   = 5;
        while (beats_sent < n) random_item();
    endtask

    // Drop valid, let every owed result drain, then give the parser a few spare cycles.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_device_id(input logic [7:0] id);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= id;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        #3_000_000;
        $display("hand_reply_frame_parser regression: fail");
        $finish;
    end

    initial begin
        logic [7:0] d[$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, device id still at its reset value of 1.
        read_beat(hrfp_pkg::TAB_ANGLE, 3'd0);
        // Angle reply: zero, all ones, 0x8000, 0x8001, 0x7FFF, then more values
        // than joints; the trailing byte never becomes a value.
        d = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h80, 8'hFF, 8'h7F,
              8'h34, 8'h12, 8'h78, 8'h56, 8'hAA};
        send_reply(8'd1, hrfp_pkg::REG_ANGLE, d);
        // Force reply with the code sent negated; it has to fold back to force.
        d = '{8'h01, 8'h80, 8'hFF, 8'hFF, 8'h5A};
        send_reply(8'd1, 16'(17'h10000 - hrfp_pkg::REG_FORCE), d);
        // Current reply of three whole pairs; the end mark drops the last pair unstored.
        d = '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'h11, 8'h22};
        send_reply(8'd1, hrfp_pkg::REG_CURRENT, d);
        d = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_reply(8'd1, hrfp_pkg::REG_ERROR, d);
        d = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
        send_reply(8'd1, hrfp_pkg::REG_STATUS, d);
        // Bare acknowledges plus two codes nobody knows.
        d.delete();
        for (int i = 5; i < 11; i++) send_reply(8'd1, KNOWN_CODES[i], d);
        send_reply(8'd1, 16'h8000, d);
        send_reply(8'd1, 16'h0000, d);
        // Short frames: six bytes, then one.
        d = '{8'h11, 8'h22, 8'h01, 8'h33, 8'h44, hrfp_pkg::REG_ANGLE[7:0]};
        send_frame(d);
        d = '{8'hFF};
        send_frame(d);
        // Wrong id: nothing stored, summary ignored.
        d = '{8'hEE, 8'hEE, 8'h11};
        send_reply(8'd2, hrfp_pkg::REG_ANGLE, d);
        // Reads wedged between the bytes of a frame must leave it intact.
        read_pct = 50;
        d = '{8'h10, 8'h20, 8'h30, 8'hC0, 8'h50, 8'h60, 8'h70};
        send_reply(8'd1, hrfp_pkg::REG_ANGLE, d);
        read_pct = 0;
        // Reads across every table and joint selector, the invalid ones too.
        for (int t = 0; t < 8; t++) begin
            read_beat(3'(t), 3'(t));
            read_beat(3'(t), 3'(7 - t));
        end

        // Random part, one run per handshake pressure and device id.
        random_run(PHASE_BEATS);
        settle();
        set_device_id(8'h00);
        gap_pct   = 81;
        stall_pct = 0;
        random_run(PHASE_BEATS);
        settle();
        set_device_id(8'hFF);
        gap_pct   = 0;
        stall_pct = 81;
        random_run(PHASE_BEATS);
        settle();
        set_device_id(8'($urandom));
        gap_pct   = 22;
        stall_pct = 22;
        random_run(PHASE_BEATS);
        settle();

        if (tracker.mismatches == 0) begin
            $display("hand_reply_frame_parser regression: pass");
        end else begin
            $display("hand_reply_frame_parser regression: fail");
        end
        $finish;
    end
endmodule
